// ===== rtl/core/wbps_pkg.sv =====
// shared types and constants of the wildcard byte pattern scanner
package wbps_pkg;

  // fixed sizes of the pattern registers
  localparam int REG_BYTES = 32;
  localparam int PAT_BITS  = REG_BYTES * 8;
  localparam int LEN_W     = 6;
  localparam int CNT_W     = 32;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_PAT0 = 3'd0,
    REG_PAT1 = 3'd1,
    REG_PAT2 = 3'd2,
    REG_PAT3 = 3'd3,
    REG_CARE = 3'd4,
    REG_LEN  = 3'd5
  } cfg_reg_t;

  // pattern setup handed to every cell
  typedef struct packed {
    logic [PAT_BITS-1:0]  pattern;
    logic [REG_BYTES-1:0] care;
    logic [LEN_W-1:0]     len;
  } pat_cfg_t;

  // one result item
  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] offset;
  } result_t;

endpackage

// ===== rtl/core/wildcard_byte_pattern_scanner_unit.sv =====
// top level of the wildcard byte pattern scanner
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data | in
//  in      | in_valid in_ready data_byte last_byte  | in
//  out     | out_valid out_ready found match_offset | out
//
// one byte item per cycle while in_ready is high; a result is queued when its item is taken.
// the compare is combinational: each cell checks the byte entering it.
// after reset and after each cfg write in_ready is low while
// the cells reload their aligned pattern bytes; cfg_ready is always high.
// results sit in a two-entry queue, and input also stalls when it is full.
module wildcard_byte_pattern_scanner_unit #(
  parameter int MAX_PATTERN_LEN = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [2:0]              cfg_index,
  input  logic [63:0]             cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              data_byte,
  input  logic                    last_byte,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    found,
  output logic [31:0]             match_offset
);
  import wbps_pkg::*;

  localparam int NCELL = (MAX_PATTERN_LEN < REG_BYTES) ? MAX_PATTERN_LEN : REG_BYTES;
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(NCELL);

  // configuration registers
  logic [PAT_BITS-1:0]  pattern;
  logic [REG_BYTES-1:0] care_mask;
  logic [LEN_W-1:0]     pattern_length;
  logic                 settle;

  // scan state
  logic [CNT_W-1:0] bytes_seen;
  logic             reported;

  logic             cfg_fire;
  logic             in_fire;
  logic [LEN_W-1:0] eff_len;
  pat_cfg_t         cell_cfg;
  logic [7:0]       chain [NCELL+1];
  logic [NCELL-1:0] hits;
  logic [CNT_W-1:0] seen_inc;
  logic             match;
  logic             res_push;
  result_t          res_item;
  result_t          head_item;
  logic             q_full;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_ready  = !settle && !q_full;
  assign in_fire   = in_valid && in_ready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern        <= '0;
      care_mask      <= '1;
      pattern_length <= LEN_W'(1);
      settle         <= 1'b1;
    end else begin
      settle <= cfg_fire;
      if (cfg_fire) begin
        unique case (cfg_index)
          REG_PAT0: pattern[0*64 +: 64] <= cfg_data;
          REG_PAT1: pattern[1*64 +: 64] <= cfg_data;
          REG_PAT2: pattern[2*64 +: 64] <= cfg_data;
          REG_PAT3: pattern[3*64 +: 64] <= cfg_data;
          REG_CARE: care_mask <= cfg_data[REG_BYTES-1:0];
          REG_LEN:  pattern_length <= cfg_data[LEN_W-1:0];
          default:  ;
        endcase
      end
    end
  end

  // effective length: zero counts as one, capped at the window depth
  always_comb begin
    if (pattern_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (pattern_length > LEN_CAP) begin
      eff_len = LEN_CAP;
    end else begin
      eff_len = pattern_length;
    end
    cell_cfg.pattern = pattern;
    cell_cfg.care    = care_mask;
    cell_cfg.len     = eff_len;
  end

  // row of window cells, newest byte enters cell 0
  assign chain[0] = data_byte;

  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    wbps_cell #(
      .CELL_IDX(j)
    ) u_cell (
      .clk     (clk),
      .shift_en(in_fire),
      .byte_in (chain[j]),
      .cfg     (cell_cfg),
      .byte_out(chain[j+1]),
      .hit     (hits[j])
    );
  end

  // match decision for the incoming item
  always_comb begin
    seen_inc = (bytes_seen == CNT_MAX) ? bytes_seen : bytes_seen + CNT_W'(1);
    match    = (&hits) && (seen_inc >= CNT_W'(eff_len));
    res_item.found  = match;
    res_item.offset = match ? (seen_inc - CNT_W'(eff_len)) : '0;
    res_push        = in_fire && !reported && (match || last_byte);
  end

  // byte count and report flag, cleared by the last item of a scan
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      reported   <= 1'b0;
    end else if (in_fire) begin
      if (last_byte) begin
        bytes_seen <= '0;
        reported   <= 1'b0;
      end else begin
        bytes_seen <= seen_inc;
        if (match) begin
          reported <= 1'b1;
        end
      end
    end
  end

  wbps_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (res_push),
    .push_item(res_item),
    .pop_ready(out_ready),
    .pop_valid(out_valid),
    .pop_item (head_item),
    .full     (q_full)
  );

  assign found        = head_item.found;
  assign match_offset = head_item.offset;

endmodule

// ===== rtl/core/wbps_cell.sv =====
// one window cell: holds a byte, passes it on, compares against its pattern byte
module wbps_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic             clk,
  input  logic             shift_en,
  input  logic [7:0]       byte_in,
  input  wbps_pkg::pat_cfg_t cfg,
  output logic [7:0]       byte_out,
  output logic             hit
);
  import wbps_pkg::*;

  localparam logic [LEN_W-1:0] IDX = LEN_W'(CELL_IDX);

  logic [7:0]       win_byte;
  logic [7:0]       pat_sel;
  logic             care_sel;
  logic [7:0]       pat_sel_next;
  logic             care_sel_next;
  logic [LEN_W-1:0] pat_pos;

  // pattern byte that lines up with this window position: len-1-idx
  always_comb begin
    pat_pos       = cfg.len - LEN_W'(1) - IDX;
    pat_sel_next  = cfg.pattern[{pat_pos[4:0], 3'b000} +: 8];
    care_sel_next = (IDX < cfg.len) && cfg.care[pat_pos[4:0]];
  end

  // aligned pattern byte, reloaded every cycle
  always_ff @(posedge clk) begin
    pat_sel  <= pat_sel_next;
    care_sel <= care_sel_next;
  end

  // window byte moves one cell on each accepted item
  always_ff @(posedge clk) begin
    if (shift_en) begin
      win_byte <= byte_in;
    end
  end

  assign byte_out = win_byte;
  assign hit      = !care_sel || (byte_in == pat_sel);

endmodule

// ===== rtl/core/wbps_outq.sv =====
// two-entry result queue between the scan logic and the output channel
module wbps_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  wbps_pkg::result_t push_item,
  input  logic              pop_ready,
  output logic              pop_valid,
  output wbps_pkg::result_t pop_item,
  output logic              full
);
  import wbps_pkg::*;

  result_t    entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign pop_item  = entry[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== rtl/core/wbps_checker.sv =====
// port-level checks of the scanner, bound to the top level
module wbps_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        found,
  input logic [31:0] match_offset
);

  // a waiting result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // a miss always carries a zero offset
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> match_offset == 32'd0)
    else $error("miss item with nonzero offset");

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result item present after reset");

  // input pauses for the cycle after a register write
  a_cfg_settle: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("input taken while pattern reloads");

endmodule

bind wildcard_byte_pattern_scanner_unit wbps_checker u_wbps_checker (.*);

// ===== dv/wildcard_byte_pattern_scanner_unit_tb.sv =====
// testbench of the wildcard byte pattern scanner unit: predicted first-match results vs. outputs
`timescale 1ns / 1ps

module wildcard_byte_pattern_scanner_unit_tb;
  import wbps_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 4;
  localparam int IDLE_LIMIT    = 1000;
  localparam int LONG_HOLD     = 150;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_ITEMS   = 133;
  localparam int MAX_REPORTS   = 100;
  // index with no register behind it, writes must be ignored
  localparam logic [2:0] SPARE_REG_IDX = 3'd7;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } scan_byte_t;

  typedef enum {SCAN_HIT, SCAN_BROKEN, SCAN_NOISE} scan_kind_t;
  typedef enum {RX_ALWAYS, RX_COIN, RX_SPARSE} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        found;
  logic [31:0] match_offset;

  // handshakes seen at the last rising edge
  bit in_fire, out_fire, cfg_fire;

  // scanner model: register copy and scan state
  logic [PAT_BITS-1:0]  pat_bits = '0;
  logic [REG_BYTES-1:0] care_bits = '1;
  logic [LEN_W-1:0]     len_reg = LEN_W'(1);
  logic [7:0]           win_bytes [REG_BYTES] = '{default: '0};
  logic [CNT_W-1:0]     scan_count = '0;
  bit                   scan_reported = 1'b0;
  result_t              pending_results [$];

  // byte items waiting for the driver
  scan_byte_t  byte_q [$];
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  // setup the stimulus is built for
  logic [PAT_BITS-1:0]  gen_pat = '0;
  logic [REG_BYTES-1:0] gen_care = '1;
  int unsigned          gen_len = 1;
  bit                   gen_narrow = 1'b0;

  // sender bursts and receiver stalls
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  int unsigned next_hold_at = 20;
  int unsigned stall_tick = 0;
  rx_mode_t    rx_mode = RX_ALWAYS;

  wildcard_byte_pattern_scanner_unit u_top (.*);

  always #CLK_HALF clk = ~clk;

  // zero length means one byte, lengths past the registers stop at their size
  function automatic int unsigned effective_length(input logic [LEN_W-1:0] l);
    if (l == 0) return 1;
    if (l > REG_BYTES) return REG_BYTES;
    return l;
  endfunction

  // shift one byte into the window and work out the result it causes
  task automatic predict_scan_byte(input logic [7:0] b, input logic last);
    int unsigned eff_len;
    bit          hit;
    result_t     res;
    eff_len = effective_length(len_reg);
    for (int i = REG_BYTES - 1; i > 0; i--) win_bytes[i] = win_bytes[i-1];
    win_bytes[0] = b;
    if (scan_count != CNT_MAX) scan_count++;
    if (!scan_reported) begin
      // no match possible until the window holds a whole pattern
      hit = (scan_count >= eff_len);
      for (int k = 0; k < eff_len; k++) begin
        if (care_bits[k] && win_bytes[eff_len-1-k] != pat_bits[8*k +: 8]) hit = 1'b0;
      end
      if (hit) begin
        res.found = 1'b1;
        res.offset = scan_count - CNT_W'(eff_len);
        scan_reported = 1'b1;
        pending_results.push_back(res);
      end else if (last) begin
        res = '0;
        pending_results.push_back(res);
      end
    end
    // end of scan clears everything but the registers
    if (last) begin
      win_bytes = '{default: '0};
      scan_count = '0;
      scan_reported = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    // keep the log short when things go badly wrong
    if (mismatches <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // monitor: model updates, result checks and watchdog
  always @(posedge clk) begin
    result_t want;
    in_fire = in_valid && in_ready;
    out_fire = out_valid && out_ready;
    cfg_fire = cfg_valid && cfg_ready;
    if (!rst) begin
      if (cfg_fire) begin
        case (cfg_index)
          REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3: pat_bits[64*cfg_index +: 64] = cfg_data;
          REG_CARE: care_bits = cfg_data[REG_BYTES-1:0];
          REG_LEN:  len_reg = cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        predict_scan_byte(data_byte, last_byte);
        bytes_taken++;
      end
      if (out_fire) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result found=%0b offset=%0d",
                                    found, match_offset));
        end else begin
          want = pending_results.pop_front();
          if (found !== want.found)
            report_mismatch($sformatf("found %0b, expected %0b", found, want.found));
          if (match_offset !== want.offset)
            report_mismatch($sformatf("match_offset %0d, expected %0d",
                                      match_offset, want.offset));
        end
      end
      idle_cycles = (in_fire || out_fire || cfg_fire) ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("wildcard_byte_pattern_scanner_unit_tb failed");
        $finish;
      end
    end
  end

  // driver: byte items in bursts with random gaps
  always @(negedge clk) begin
    scan_byte_t next_item;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      // item still offered, hold it
    end else if (gap_left != 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (byte_q.size() != 0) begin
      next_item = byte_q.pop_front();
      in_valid <= 1'b1;
      data_byte <= next_item.value;
      last_byte <= next_item.last;
      if (burst_left <= 1) begin
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160)
                                                  : $urandom_range(1, 12);
        gap_left = $urandom_range(1, 6);
      end else begin
        burst_left--;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver: stall modes picked at random, plus long hold-offs
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (results_seen >= next_hold_at) begin
      out_ready <= 1'b0;
      hold_left = LONG_HOLD;
      next_hold_at += 25;
    end else begin
      stall_tick++;
      if (stall_tick % 64 == 0) rx_mode = rx_mode_t'($urandom_range(0, 2));
      case (rx_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        default:   out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // write every register; unused upper data bits carry noise
  task automatic load_setup(input logic [PAT_BITS-1:0] pat, input logic [31:0] care,
                            input logic [LEN_W-1:0] len);
    for (int w = 0; w < 4; w++) write_reg(cfg_reg_t'(REG_PAT0 + w), pat[64*w +: 64]);
    write_reg(REG_CARE, {$urandom, care});
    write_reg(REG_LEN, {(64 - LEN_W)'({$urandom, $urandom}), len});
    gen_pat = pat;
    gen_care = care;
    gen_len = effective_length(len);
  endtask

  task automatic queue_byte(input logic [7:0] value, input logic last);
    byte_q.push_back('{value: value, last: last});
    bytes_queued++;
  endtask

  // small alphabet makes partial matches and overlaps common
  function automatic logic [7:0] pick_byte();
    return gen_narrow ? 8'h41 + 8'($urandom_range(0, 2)) : 8'($urandom_range(0, 255));
  endfunction

  // one scan of random bytes, with the pattern planted unless it is noise
  task automatic queue_scan(input scan_kind_t kind);
    int unsigned n, start, pos;
    logic [7:0]  bytes [$];
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 80) : $urandom_range(1, gen_len + 10);
    for (int i = 0; i < n; i++) bytes.push_back(pick_byte());
    if (kind != SCAN_NOISE && n >= gen_len) begin
      start = $urandom_range(0, n - gen_len);
      for (int k = 0; k < gen_len; k++) begin
        if (gen_care[k]) bytes[start+k] = gen_pat[8*k +: 8];
      end
      if (kind == SCAN_BROKEN) begin
        pos = start + $urandom_range(0, gen_len - 1);
        bytes[pos] = bytes[pos] ^ 8'($urandom_range(1, 255));
      end
    end
    for (int i = 0; i < n; i++) queue_byte(bytes[i], i == n - 1);
  endtask

  // wait until every item is taken and every result has come back
  task automatic wait_for_drain();
    do @(negedge clk); while (bytes_taken != bytes_queued || pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // stimulus sequence
  initial begin
    logic [PAT_BITS-1:0]  pat;
    logic [REG_BYTES-1:0] care;
    logic [LEN_W-1:0]     len;
    int unsigned          phase_start;
    int unsigned          pick;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset setup: miss on last byte, hit on last byte, last byte after a hit
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h55, 1'b1);
    wait_for_drain();

    // spare index is ignored; zero length acts as one byte
    write_reg(SPARE_REG_IDX, {$urandom, $urandom});
    load_setup(PAT_BITS'(8'hAB), '1, LEN_W'(0));
    queue_byte(8'h12, 1'b0);
    queue_byte(8'hAB, 1'b1);
    wait_for_drain();

    // all wildcards: hit once three bytes are in
    load_setup(PAT_BITS'(32'h0), '0, LEN_W'(3));
    for (int i = 1; i <= 5; i++) queue_byte(8'(i), i == 5);
    wait_for_drain();

    // DE AD ?? EF with a near miss before the real match
    load_setup(PAT_BITS'(32'hEF00ADDE), 32'hB, LEN_W'(4));
    queue_byte(8'hDE, 1'b0);
    queue_byte(8'hAD, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hEE, 1'b0);
    queue_byte(8'hDE, 1'b0);
    queue_byte(8'hAD, 1'b0);
    queue_byte(8'h77, 1'b0);
    queue_byte(8'hEF, 1'b1);
    wait_for_drain();

    // random phases, first few pinned to the extremes
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      gen_narrow = ($urandom_range(0, 2) == 0);
      for (int k = 0; k < REG_BYTES; k++) pat[8*k +: 8] = pick_byte();
      care = '1;
      case (p)
        0: len = LEN_W'(REG_BYTES);
        1: begin
          pat = '1;
          care = '0;
          len = '1;
        end
        2: len = LEN_W'(1);
        3: begin
          len = '0;
          care = $urandom;
        end
        default: begin
          len = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom_range(13, 63))
                                            : LEN_W'($urandom_range(2, 12));
          pick = $urandom_range(0, 3);
          if (pick == 1) care = $urandom;
          else if (pick == 2) care = ~(32'd1 << $urandom_range(0, 31));
        end
      endcase
      load_setup(pat, care, len);
      phase_start = bytes_queued;
      while (bytes_queued - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        queue_scan(pick < 7 ? SCAN_HIT : (pick < 9 ? SCAN_BROKEN : SCAN_NOISE));
      end
      wait_for_drain();
    end

    if (mismatches == 0) begin
      $display("wildcard_byte_pattern_scanner_unit_tb passed");
    end else begin
      $display("wildcard_byte_pattern_scanner_unit_tb failed");
    end
    $finish;
  end

endmodule
